[design/thtc_pkg.sv]
// Shared constants, types and register codes for the thermistor conversion pipeline.
package thtc_pkg;

    localparam int ADC_BITS     = 10;
    localparam int FULL_CODE    = (1 << ADC_BITS) - 1;
    localparam int S_TDATA_W    = ((ADC_BITS + 7) / 8) * 8;

    localparam int SER_W        = 20;
    localparam int COEF_W       = 32;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 4;

    // log2 unit: integer input, Q1.30 mantissa, Q28 result
    localparam int X_W          = SER_W + ADC_BITS;
    localparam int E_W          = $clog2(X_W);
    localparam int NORM_POS     = 30;
    localparam int M_W          = NORM_POS + 1;
    localparam int LOG_FRAC     = 28;
    localparam int LOG_W        = E_W + LOG_FRAC;

    // natural log scaling and polynomial
    localparam int LN2_SH       = 30;
    localparam logic [LN2_SH-1:0] LN2_Q30 = LN2_SH'(744261118);
    localparam int LN_FRAC_BITS = 16;
    localparam int RSH          = LOG_FRAC - LN_FRAC_BITS;
    localparam int L_W          = LOG_W + 1 - RSH;
    localparam int L2_W         = 2 * L_W - LN_FRAC_BITS;
    localparam int BT_W         = COEF_W + L_W - LN_FRAC_BITS;
    localparam int L3_W         = L_W + L2_W - LN_FRAC_BITS;
    localparam int CT_W         = COEF_W + L3_W - LN_FRAC_BITS;
    localparam int DEN_SW       = CT_W + 2;

    // reciprocal: k = (100 * 2^40 + d/2) / d
    localparam int D_W          = DEN_SW - 1;
    localparam int N_W          = D_W + 1;
    localparam int Q_BITS       = 17;
    localparam int REM_W        = D_W + Q_BITS;
    localparam int KELVIN_SCALE = 100;
    localparam int COEF_FRAC    = 40;
    localparam logic [N_W-1:0] K_NUM = N_W'(KELVIN_SCALE) << COEF_FRAC;

    localparam int TEMP_W       = 17;
    localparam int TEMP_HIGH    = 50000;
    localparam int KELVIN_CENTI = 27315;
    localparam int K_SAT        = TEMP_HIGH + KELVIN_CENTI;
    localparam int M_TDATA_W    = ((TEMP_W + 7) / 8) * 8;

    localparam logic [SER_W-1:0]  SERIES_RST = SER_W'(10000);
    localparam logic [COEF_W-1:0] COEF_A_RST = COEF_W'(1241511355);
    localparam logic [COEF_W-1:0] COEF_B_RST = COEF_W'(257423160);
    localparam logic [COEF_W-1:0] COEF_C_RST = COEF_W'(96399);

    typedef enum logic [1:0] {
        REG_SERIES,
        REG_COEF_A,
        REG_COEF_B,
        REG_COEF_C
    } reg_idx_t;

    typedef struct packed {
        logic valid;
        logic invalid;
    } meta_t;

    typedef struct packed {
        logic [SER_W-1:0]  series;
        logic [COEF_W-1:0] coef_a;
        logic [COEF_W-1:0] coef_b;
        logic [COEF_W-1:0] coef_c;
    } cfg_t;

endpackage

[design/thtc_regs.sv]
// APB register file holding the divider resistor and the three coefficients.
module thtc_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [thtc_pkg::ADDR_W-1:0] paddr,
    input  logic [thtc_pkg::DATA_W-1:0] pwdata,
    output logic [thtc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output thtc_pkg::cfg_t              cfg
);
    import thtc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.series <= SERIES_RST;
            cfg_reg.coef_a <= COEF_A_RST;
            cfg_reg.coef_b <= COEF_B_RST;
            cfg_reg.coef_c <= COEF_C_RST;
        end else if (wr_en) begin
            case (idx)
                REG_SERIES: cfg_reg.series <= pwdata[SER_W-1:0];
                REG_COEF_A: cfg_reg.coef_a <= pwdata[COEF_W-1:0];
                REG_COEF_B: cfg_reg.coef_b <= pwdata[COEF_W-1:0];
                REG_COEF_C: cfg_reg.coef_c <= pwdata[COEF_W-1:0];
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SERIES: prdata = DATA_W'(cfg_reg.series);
            REG_COEF_A: prdata = DATA_W'(cfg_reg.coef_a);
            REG_COEF_B: prdata = DATA_W'(cfg_reg.coef_b);
            REG_COEF_C: prdata = DATA_W'(cfg_reg.coef_c);
            default:    prdata = '0;
        endcase
    end

endmodule

[design/thtc_log2.sv]
// Two-lane pipelined log2 in Q28: normalize, then one squaring step per stage.
module thtc_log2 (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  thtc_pkg::meta_t            meta_in,
    input  logic [thtc_pkg::X_W-1:0]   x_num,
    input  logic [thtc_pkg::X_W-1:0]   x_den,
    output thtc_pkg::meta_t            meta_out,
    output logic [thtc_pkg::LOG_W-1:0] log_num,
    output logic [thtc_pkg::LOG_W-1:0] log_den
);
    import thtc_pkg::*;

    function automatic logic [E_W-1:0] top_bit(input logic [X_W-1:0] x);
        logic [E_W-1:0] e;
        e = '0;
        for (int i = 0; i < X_W; i++) begin
            if (x[i]) e = E_W'(i);
        end
        return e;
    endfunction

    logic [X_W-1:0]      x_in [0:1];
    logic [X_W-1:0]      x_a_reg [0:1];
    logic [E_W-1:0]      e_a_reg [0:1];
    meta_t               meta_a_reg;
    logic [M_W-1:0]      m_reg [0:LOG_FRAC][0:1];
    logic [E_W-1:0]      e_reg [0:LOG_FRAC][0:1];
    logic [LOG_FRAC-1:0] f_reg [0:LOG_FRAC][0:1];
    meta_t               meta_reg [0:LOG_FRAC];

    assign x_in[0] = x_num;
    assign x_in[1] = x_den;

    // find the top set bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_a_reg <= '0;
        end else if (adv) begin
            meta_a_reg <= meta_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                x_a_reg[l] <= x_in[l];
                e_a_reg[l] <= top_bit(x_in[l]);
            end
        end
    end

    // shift to Q1.30
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_reg[0] <= '0;
        end else if (adv) begin
            meta_reg[0] <= meta_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                m_reg[0][l] <= {1'b0, x_a_reg[l]} << (E_W'(NORM_POS) - e_a_reg[l]);
                e_reg[0][l] <= e_a_reg[l];
                f_reg[0][l] <= '0;
            end
        end
    end

    for (genvar gi = 0; gi < LOG_FRAC; gi++) begin : g_sq
        logic [2*M_W-1:0] sq [0:1];
        logic [M_W:0]     sh [0:1];

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                sq[l] = m_reg[gi][l] * m_reg[gi][l];
                sh[l] = sq[l][NORM_POS+M_W:NORM_POS];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                meta_reg[gi+1] <= '0;
            end else if (adv) begin
                meta_reg[gi+1] <= meta_reg[gi];
            end
        end

        // square; a mantissa at or above two yields a one bit and halves
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int l = 0; l < 2; l++) begin
                    e_reg[gi+1][l] <= e_reg[gi][l];
                    if (sh[l][M_W]) begin
                        m_reg[gi+1][l] <= sh[l][M_W:1];
                        f_reg[gi+1][l] <= {f_reg[gi][l][LOG_FRAC-2:0], 1'b1};
                    end else begin
                        m_reg[gi+1][l] <= sh[l][M_W-1:0];
                        f_reg[gi+1][l] <= {f_reg[gi][l][LOG_FRAC-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign meta_out = meta_reg[LOG_FRAC];
    assign log_num  = {e_reg[LOG_FRAC][0], f_reg[LOG_FRAC][0]};
    assign log_den  = {e_reg[LOG_FRAC][1], f_reg[LOG_FRAC][1]};

endmodule

[design/thtc_poly.sv]
// Pipelined ln R scaling and Steinhart-Hart denominator A + B*L + C*L^3 in Q40.
module thtc_poly (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  thtc_pkg::cfg_t                    cfg,
    input  thtc_pkg::meta_t                   meta_in,
    input  logic [thtc_pkg::LOG_W-1:0]        log_num,
    input  logic [thtc_pkg::LOG_W-1:0]        log_den,
    output thtc_pkg::meta_t                   meta_out,
    output logic signed [thtc_pkg::DEN_SW-1:0] den
);
    import thtc_pkg::*;

    localparam int NST = 7;

    meta_t              meta_reg [1:NST];
    logic               neg_reg  [1:NST-1];
    logic [LOG_W-1:0]   mag1_reg;
    logic [LOG_W-1:0]   mag2_reg;
    logic [L_W-1:0]     lmag_reg [3:4];
    logic [L2_W-1:0]    l2_reg;
    logic [BT_W-1:0]    bt_reg   [4:6];
    logic [L3_W-1:0]    l3_reg;
    logic [CT_W-1:0]    ct_reg;
    logic signed [DEN_SW-1:0] den_reg;

    logic [LOG_W+LN2_SH-1:0] ln_prod;
    logic [LOG_W:0]          rnd_sum;
    logic [2*L_W-1:0]        sq;
    logic [COEF_W+L_W-1:0]   bp;
    logic [L_W+L2_W-1:0]     cube;
    logic [COEF_W+L3_W-1:0]  cp;
    logic [DEN_SW-1:0]       terms;

    assign ln_prod = mag1_reg * LN2_Q30;
    assign rnd_sum = {1'b0, mag2_reg} + (LOG_W+1)'(1 << (RSH - 1));
    assign sq      = lmag_reg[3] * lmag_reg[3];
    assign bp      = cfg.coef_b * lmag_reg[3];
    assign cube    = lmag_reg[4] * l2_reg;
    assign cp      = cfg.coef_c * l3_reg;
    assign terms   = DEN_SW'(bt_reg[6]) + DEN_SW'(ct_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 1; s <= NST; s++) meta_reg[s] <= '0;
        end else if (adv) begin
            meta_reg[1] <= meta_in;
            for (int s = 2; s <= NST; s++) meta_reg[s] <= meta_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // sign and magnitude of log2(num) - log2(den)
            neg_reg[1] <= log_num < log_den;
            mag1_reg   <= (log_num < log_den) ? log_den - log_num : log_num - log_den;
            for (int s = 2; s < NST; s++) neg_reg[s] <= neg_reg[s-1];
            // times ln 2
            mag2_reg    <= ln_prod[LOG_W+LN2_SH-1:LN2_SH];
            // round half up to the ln fraction
            lmag_reg[3] <= rnd_sum[LOG_W:RSH];
            lmag_reg[4] <= lmag_reg[3];
            l2_reg      <= sq[2*L_W-1:LN_FRAC_BITS];
            bt_reg[4]   <= bp[COEF_W+L_W-1:LN_FRAC_BITS];
            bt_reg[5]   <= bt_reg[4];
            bt_reg[6]   <= bt_reg[5];
            l3_reg      <= cube[L_W+L2_W-1:LN_FRAC_BITS];
            ct_reg      <= cp[COEF_W+L3_W-1:LN_FRAC_BITS];
            if (neg_reg[NST-1]) begin
                den_reg <= $signed(DEN_SW'(cfg.coef_a) - terms);
            end else begin
                den_reg <= $signed(DEN_SW'(cfg.coef_a) + terms);
            end
        end
    end

    assign meta_out = meta_reg[NST];
    assign den      = den_reg;

endmodule

[design/thtc_div.sv]
// Restoring divider, one quotient bit per stage, with saturation to the output range.
module thtc_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  thtc_pkg::meta_t                    meta_in,
    input  logic signed [thtc_pkg::DEN_SW-1:0] den,
    output thtc_pkg::meta_t                    meta_out,
    output logic signed [thtc_pkg::TEMP_W-1:0] temp
);
    import thtc_pkg::*;

    logic [D_W-1:0]    d_reg   [0:Q_BITS];
    logic [REM_W-1:0]  rem_reg [0:Q_BITS];
    logic [Q_BITS-1:0] q_reg   [0:Q_BITS];
    logic              sat_reg [0:Q_BITS];
    meta_t             meta_reg [0:Q_BITS];

    logic             nonpos;
    logic [D_W-1:0]   d_in;
    logic [N_W-1:0]   numer;
    logic [REM_W-1:0] limit;

    assign nonpos = den[DEN_SW-1] || (den == '0);
    assign d_in   = den[D_W-1:0];
    assign numer  = K_NUM + N_W'(d_in >> 1);
    assign limit  = REM_W'(d_in) << Q_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= Q_BITS; s++) meta_reg[s] <= '0;
        end else if (adv) begin
            meta_reg[0] <= meta_in;
            for (int s = 1; s <= Q_BITS; s++) meta_reg[s] <= meta_reg[s-1];
        end
    end

    // a quotient that needs more than Q_BITS bits is past the top of the range
    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg[0]   <= d_in;
            rem_reg[0] <= REM_W'(numer);
            q_reg[0]   <= '0;
            sat_reg[0] <= nonpos || (REM_W'(numer) >= limit);
        end
    end

    for (genvar gk = 0; gk < Q_BITS; gk++) begin : g_bit
        logic [REM_W-1:0] trial;
        assign trial = REM_W'(d_reg[gk]) << (Q_BITS - 1 - gk);

        always_ff @(posedge aclk) begin
            if (adv) begin
                d_reg[gk+1]   <= d_reg[gk];
                sat_reg[gk+1] <= sat_reg[gk];
                if (rem_reg[gk] >= trial) begin
                    rem_reg[gk+1] <= rem_reg[gk] - trial;
                    q_reg[gk+1]   <= {q_reg[gk][Q_BITS-2:0], 1'b1};
                end else begin
                    rem_reg[gk+1] <= rem_reg[gk];
                    q_reg[gk+1]   <= {q_reg[gk][Q_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        if (meta_reg[Q_BITS].invalid) begin
            temp = '0;
        end else if (sat_reg[Q_BITS] || (q_reg[Q_BITS] > Q_BITS'(K_SAT))) begin
            temp = TEMP_W'(TEMP_HIGH);
        end else begin
            temp = $signed(TEMP_W'(q_reg[Q_BITS]) - TEMP_W'(KELVIN_CENTI));
        end
    end

    assign meta_out = meta_reg[Q_BITS];

endmodule

[design/thermistor_to_temperature_top.sv]
// Top level: thermistor ADC code to temperature in hundredths of a degree Celsius.
//
//  channel   ports          direction  contents
//  input     s_t*           in         tdata[9:0] adc_code
//  result    m_t*           out        tdata[16:0] temp_centi_c, tuser[0] invalid
//  config    psel/penable   in/out     APB, 4 registers at byte addresses 0, 4, 8, 12
//
//  One item enters per cycle while the output is not stalled. The pipeline has input
//  and product stages, 30 log2 stages, 7 polynomial stages, 18 divider stages and
//  an output register; the 28 squaring steps of the log2 and the 17 quotient bits
//  of the divider set that depth. Reset clears all valid bits and loads the
//  register defaults. While the output holds an untaken result, the whole
//  pipeline holds and s_tready drops.
module thermistor_to_temperature_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [thtc_pkg::S_TDATA_W-1:0] s_tdata,   // [9:0] adc_code
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [thtc_pkg::M_TDATA_W-1:0] m_tdata,   // [16:0] temp_centi_c
    output logic [0:0]                     m_tuser,   // [0] invalid
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [thtc_pkg::ADDR_W-1:0]    paddr,
    input  logic [thtc_pkg::DATA_W-1:0]    pwdata,
    output logic [thtc_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import thtc_pkg::*;

    cfg_t                     cfg;
    logic                     adv;
    logic [ADC_BITS-1:0]      code_in;
    logic [ADC_BITS-1:0]      code_reg;
    meta_t                    meta1_reg;
    meta_t                    meta2_reg;
    logic [X_W-1:0]           xnum_reg;
    logic [X_W-1:0]           xden_reg;
    logic [X_W-1:0]           xnum_next;
    meta_t                    log_meta;
    logic [LOG_W-1:0]         log_num;
    logic [LOG_W-1:0]         log_den;
    meta_t                    poly_meta;
    logic signed [DEN_SW-1:0] den;
    meta_t                    div_meta;
    logic signed [TEMP_W-1:0] temp;
    logic                     m_tvalid_reg;
    logic [TEMP_W-1:0]        temp_reg;
    logic                     invalid_reg;

    thtc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // advance unless the output register holds a result nobody takes
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign code_in  = s_tdata[ADC_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta1_reg <= '0;
            meta2_reg <= '0;
        end else if (adv) begin
            meta1_reg.valid   <= s_tvalid;
            meta1_reg.invalid <= (code_in == '0) || (code_in == ADC_BITS'(FULL_CODE))
                                 || (cfg.series == '0);
            meta2_reg <= meta1_reg;
        end
    end

    assign xnum_next = cfg.series * (ADC_BITS'(FULL_CODE) - code_reg);

    // feed ones on invalid items to keep the log2 input nonzero
    always_ff @(posedge aclk) begin
        if (adv) begin
            code_reg <= code_in;
            xnum_reg <= meta1_reg.invalid ? X_W'(1) : xnum_next;
            xden_reg <= meta1_reg.invalid ? X_W'(1) : X_W'(code_reg);
        end
    end

    thtc_log2 u_log2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .meta_in  (meta2_reg),
        .x_num    (xnum_reg),
        .x_den    (xden_reg),
        .meta_out (log_meta),
        .log_num  (log_num),
        .log_den  (log_den)
    );

    thtc_poly u_poly (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .cfg      (cfg),
        .meta_in  (log_meta),
        .log_num  (log_num),
        .log_den  (log_den),
        .meta_out (poly_meta),
        .den      (den)
    );

    thtc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .meta_in  (poly_meta),
        .den      (den),
        .meta_out (div_meta),
        .temp     (temp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= div_meta.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            temp_reg    <= temp;
            invalid_reg <= div_meta.invalid;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = M_TDATA_W'(temp_reg);
    assign m_tuser[0] = invalid_reg;

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (temp_reg == '0))
        else $error("invalid result with nonzero temperature");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(temp_reg) <= $signed(TEMP_W'(TEMP_HIGH)))
                      && ($signed(temp_reg) >= $signed(-TEMP_W'(KELVIN_CENTI)))))
        else $error("temperature out of range");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    a_tail_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(div_meta))
        else $error("pipeline tail moved during output stall");

endmodule
